// ----- hw/rtl/clv_pkg.sv -----
// Package for the command line checksum validator.
// Holds the transfer payload types, character and status codes and the hex helper.
// Depends on nothing.
`timescale 1ns / 1ps

package clv_pkg;

  localparam logic [7:0] CharNul   = 8'd0;
  localparam logic [7:0] CharTab   = 8'd9;
  localparam logic [7:0] CharNl    = 8'd10;
  localparam logic [7:0] CharCr    = 8'd13;
  localparam logic [7:0] CharSpace = 8'd32;
  localparam logic [7:0] CharPlus  = 8'd43;
  localparam logic [7:0] CharComma = 8'd44;
  localparam logic [7:0] CharMinus = 8'd45;
  localparam logic [7:0] CharZero  = 8'd48;
  localparam logic [7:0] CharNine  = 8'd57;

  localparam logic [7:0] MinLineLen = 8'd4;
  localparam logic [7:0] TailDepth  = 8'd3;
  localparam logic [7:0] CountMax   = 8'd255;

  localparam logic [31:0] SeqMagLimit = 32'h8000_0000;
  localparam logic [31:0] SeqPosMax   = 32'h7FFF_FFFF;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_SHORT     = 3'd1,
    STAT_CHECKSUM  = 3'd2,
    STAT_NO_COMMA  = 3'd3,
    STAT_OVERFLOW  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    PH_SKIP   = 2'd0,
    PH_DIGITS = 2'd1,
    PH_DONE   = 2'd2
  } seq_phase_t;

  typedef struct packed {
    logic [7:0] rx_byte;
  } rx_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] sequence_res;
    logic [7:0]         line_length;
  } result_t;

  typedef struct packed {
    logic [7:0]       char_count;
    logic [2:0][7:0]  tail_chars;
    logic [7:0]       running_xor;
    logic             comma_seen;
    logic [31:0]      seq_accum;
    seq_phase_t       seq_phase;
    logic             seq_negative;
    logic             overflowed;
  } line_state_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] w;
    w = {4'd0, v};
    return (v < 4'd10) ? (8'd48 + w) : (8'd55 + w);
  endfunction

endpackage

// ----- hw/rtl/clv_stream_if.sv -----
// Valid/ready stream interface used for both channels of the validator.
// The payload type is a parameter; the types come from clv_pkg.
`timescale 1ns / 1ps

interface clv_stream_if #(
  parameter type T = clv_pkg::rx_item_t
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/clv_line_track.sv -----
// Per-line state of the validator: counts, the three-character tail, the
// running XOR, comma detection and the decimal sequence parser. Uses clv_pkg.
`timescale 1ns / 1ps

module clv_line_track #(
  parameter int MAX_LINE = 255
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic                 clear,
  input  logic [7:0]           char_in,
  output clv_pkg::line_state_t st
);

  localparam int RawW = $clog2(MAX_LINE + 1);

  clv_pkg::line_state_t st_next;
  logic [RawW-1:0]      raw_count;
  logic [RawW-1:0]      raw_count_next;
  logic                 nul_seen;
  logic                 nul_seen_next;

  logic [7:0]  tc;
  logic        is_ws;
  logic        is_sign;
  logic        is_digit;
  logic        consumed;
  logic [35:0] prod;

  always_comb begin
    st_next        = st;
    raw_count_next = raw_count;
    nul_seen_next  = nul_seen;
    tc             = st.tail_chars[0];
    is_ws          = (tc == clv_pkg::CharSpace) ||
                     (tc >= clv_pkg::CharTab && tc <= clv_pkg::CharCr);
    is_sign        = (tc == clv_pkg::CharPlus) || (tc == clv_pkg::CharMinus);
    is_digit       = (tc >= clv_pkg::CharZero) && (tc <= clv_pkg::CharNine);
    consumed       = 1'b0;
    prod           = ({4'd0, st.seq_accum} << 3) + ({4'd0, st.seq_accum} << 1)
                     + {28'd0, tc - clv_pkg::CharZero};

    if (step) begin
      if (raw_count >= RawW'(MAX_LINE)) begin
        st_next.overflowed = 1'b1;
      end else begin
        raw_count_next = raw_count + RawW'(1);
      end

      if (!nul_seen) begin
        if (char_in == clv_pkg::CharNul) begin
          nul_seen_next = 1'b1;
        end else begin
          // The oldest tail character joins the checked part of the line.
          if (st.char_count >= clv_pkg::TailDepth) begin
            st_next.running_xor = st.running_xor ^ tc;
            if (!st.comma_seen) begin
              if (tc == clv_pkg::CharComma) begin
                st_next.comma_seen = 1'b1;
                st_next.seq_phase  = clv_pkg::PH_DONE;
              end else begin
                if (st.seq_phase == clv_pkg::PH_SKIP) begin
                  if (is_ws) begin
                    consumed = 1'b1;
                  end else if (is_sign) begin
                    st_next.seq_negative = (tc == clv_pkg::CharMinus);
                    st_next.seq_phase    = clv_pkg::PH_DIGITS;
                    consumed             = 1'b1;
                  end else begin
                    st_next.seq_phase = clv_pkg::PH_DIGITS;
                  end
                end
                if (!consumed && st_next.seq_phase == clv_pkg::PH_DIGITS) begin
                  if (is_digit) begin
                    st_next.seq_accum = (prod > {4'd0, clv_pkg::SeqMagLimit}) ?
                                        clv_pkg::SeqMagLimit : prod[31:0];
                  end else begin
                    st_next.seq_phase = clv_pkg::PH_DONE;
                  end
                end
              end
            end
          end
          st_next.tail_chars[0] = st.tail_chars[1];
          st_next.tail_chars[1] = st.tail_chars[2];
          st_next.tail_chars[2] = char_in;
          if (st.char_count < clv_pkg::CountMax) begin
            st_next.char_count = st.char_count + 8'd1;
          end
        end
      end
    end

    if (clear) begin
      st_next        = '0;
      raw_count_next = '0;
      nul_seen_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= '0;
      raw_count <= '0;
      nul_seen  <= 1'b0;
    end else begin
      st        <= st_next;
      raw_count <= raw_count_next;
      nul_seen  <= nul_seen_next;
    end
  end

endmodule

// ----- hw/rtl/command_line_checksum_validator.sv -----
// Top level of the command line checksum validator.
// Uses clv_pkg, clv_stream_if and clv_line_track.
//
// Bytes arrive on the rx channel, one per transfer; a newline byte closes the
// line and produces exactly one transfer on the result channel carrying the
// status, the parsed sequence number and the line length. All other bytes
// produce no result.
// Each accepted byte is held in an input register and is then folded into
// the line state, so the block takes one byte every cycle unless a newline
// waits in the input register. A result is loaded into a registered output
// when its newline leaves the input register, so a newline passes the input
// register and then the output register before its result is offered.
// When the receiver stalls, ordinary bytes keep flowing into the line state;
// only a newline that finds the output register still full waits in the
// input register, and rx.ready drops until the pending result is taken.
// Synchronous reset empties both registers and clears the line state to an
// empty line; no result is pending after reset.
// A line of more than MAX_LINE bytes before its newline reports overflow.
`timescale 1ns / 1ps

module command_line_checksum_validator #(
  parameter int MAX_LINE = 255
) (
  input  logic             clk,
  input  logic             rst,
  clv_stream_if.sink       rx,
  clv_stream_if.source     result
);

  logic                 hold_valid;
  logic [7:0]           hold_byte;
  logic                 hold_is_nl;
  logic                 out_free;
  logic                 advance;
  logic                 res_valid;
  clv_pkg::result_t     res_data;
  clv_pkg::result_t     res_data_next;
  clv_pkg::line_state_t line_st;

  assign hold_is_nl = (hold_byte == clv_pkg::CharNl);
  assign out_free   = !res_valid || result.ready;
  assign advance    = hold_valid && (!hold_is_nl || out_free);
  assign rx.ready   = !hold_valid || advance;

  clv_line_track #(
    .MAX_LINE (MAX_LINE)
  ) u_track (
    .clk     (clk),
    .rst     (rst),
    .step    (advance && !hold_is_nl),
    .clear   (advance && hold_is_nl),
    .char_in (hold_byte),
    .st      (line_st)
  );

  always_comb begin
    res_data_next              = '0;
    res_data_next.line_length  = line_st.char_count;
    if (line_st.overflowed) begin
      res_data_next.status = clv_pkg::STAT_OVERFLOW;
    end else if (line_st.char_count < clv_pkg::MinLineLen) begin
      res_data_next.status = clv_pkg::STAT_SHORT;
    end else if (line_st.tail_chars[1] != clv_pkg::hex_digit(line_st.running_xor[7:4]) ||
                 line_st.tail_chars[2] != clv_pkg::hex_digit(line_st.running_xor[3:0])) begin
      res_data_next.status = clv_pkg::STAT_CHECKSUM;
    end else if (!line_st.comma_seen) begin
      res_data_next.status = clv_pkg::STAT_NO_COMMA;
    end else begin
      res_data_next.status = clv_pkg::STAT_OK;
      if (line_st.seq_negative) begin
        res_data_next.sequence_res = 32'd0 - line_st.seq_accum;
      end else if (line_st.seq_accum > clv_pkg::SeqPosMax) begin
        res_data_next.sequence_res = clv_pkg::SeqPosMax;
      end else begin
        res_data_next.sequence_res = line_st.seq_accum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      hold_byte <= rx.payload.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance && hold_is_nl) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && hold_is_nl) begin
      res_data <= res_data_next;
    end
  end

  assign result.valid   = res_valid;
  assign result.payload = res_data;

  a_nl_gives_result: assert property (@(posedge clk) disable iff (rst)
    (advance && hold_is_nl) |=> result.valid)
    else $error("newline did not load a result");

  a_nl_clears_line: assert property (@(posedge clk) disable iff (rst)
    (advance && hold_is_nl) |=> (line_st.char_count == 8'd0 && !line_st.overflowed))
    else $error("line state not cleared after newline");

  a_ok_needs_length: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.payload.status == clv_pkg::STAT_OK)
      |-> (result.payload.line_length >= clv_pkg::MinLineLen))
    else $error("ok status on a line that is too short");

  a_stall_holds_nl: assert property (@(posedge clk) disable iff (rst)
    (hold_valid && hold_is_nl && !out_free) |=> (hold_valid && hold_is_nl))
    else $error("stalled newline lost from input register");

endmodule
